// File: rtl/lsou_pkg.sv
// ----------------------------------------------------------------------------
// lsou_pkg
// Shared types and constants for the opcode-driven LIFO stack.
// ----------------------------------------------------------------------------
package lsou_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         count_t;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_DUMP = 3'd1,
    OP_PEEK = 3'd2,
    OP_POP  = 3'd3,
    OP_SWAP = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    STS_DONE       = 3'd0,
    STS_DATA       = 3'd1,
    STS_PEEK_EMPTY = 3'd2,
    STS_POP_EMPTY  = 3'd3,
    STS_SWAP_SHORT = 3'd4,
    STS_OVERFLOW   = 3'd5
  } status_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_PUSH = 3'd1,  // take the entry from above
    CELL_POP  = 3'd2,  // take the entry from below
    CELL_SWAP = 3'd3,  // top two cells exchange
    CELL_ROT  = 3'd4   // like pop, bottom valid cell takes the top entry
  } cell_op_t;

  // Where a cell sits relative to the live part of the stack
  typedef struct packed {
    logic is_top;
    logic is_second;
    logic is_bottom;
  } cell_pos_t;

endpackage

// File: rtl/lifo_stack_opcode_unit.sv
// ----------------------------------------------------------------------------
// lifo_stack_opcode_unit
// Bounded LIFO stack of signed 32-bit entries built as a chain of cells.
// ----------------------------------------------------------------------------
// The stack is a row of 64 cells, cell 0 holding the top entry; push shifts
// the row down, pop shifts it up, swap exchanges the two top cells. Push,
// pop, peek and swap each produce one result beat in the cycle after the
// opcode is taken, so a new opcode can be taken every cycle while the
// consumer keeps up. A dump takes the opcode and then gives one beat per
// stored entry (top first, tlast on the final one); the first beat passes
// through the dump state and then the result register. The
// chain rotates by one cell per beat and the top cell is read out, so after
// the dump the stack is back in its original order. No opcode is taken
// during a dump. An empty-stack dump and undefined opcodes give one beat
// with status "done". Errors leave the stack unchanged.
module lifo_stack_opcode_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] push_value
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] data_value
  output logic [2:0]  m_tuser,   // [2:0] status
  output logic        m_tlast    // last_result
);

  lsou_pkg::data_t     cell_value [lsou_pkg::STACK_DEPTH];
  lsou_pkg::cell_op_t  cell_op;
  lsou_pkg::count_t    count;
  lsou_pkg::data_t     m_data;

  lsou_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .opcode    (s_tuser),
    .top_value (cell_value[0]),
    .cell_op   (cell_op),
    .count     (count),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_data    (m_data),
    .m_status  (m_tuser),
    .m_last    (m_tlast)
  );

  assign m_tdata = m_data;

  for (genvar i = 0; i < lsou_pkg::STACK_DEPTH; i++) begin : g_cell
    lsou_pkg::cell_pos_t pos;
    lsou_pkg::data_t     up_data;
    lsou_pkg::data_t     down_data;

    assign pos.is_top    = (i == 0);
    assign pos.is_second = (i == 1);
    assign pos.is_bottom = (count == lsou_pkg::CNT_W'(i + 1));

    if (i == 0) begin : g_first
      assign up_data = s_tdata;
    end else begin : g_mid_up
      assign up_data = cell_value[i-1];
    end

    if (i == lsou_pkg::STACK_DEPTH - 1) begin : g_last
      assign down_data = cell_value[i];
    end else begin : g_mid_down
      assign down_data = cell_value[i+1];
    end

    lsou_cell u_cell (
      .clk       (clk),
      .op        (cell_op),
      .pos       (pos),
      .up_data   (up_data),
      .down_data (down_data),
      .top_data  (cell_value[0]),
      .value     (cell_value[i])
    );
  end

endmodule

// File: rtl/lsou_cell.sv
// ----------------------------------------------------------------------------
// lsou_cell
// One stack entry; loads from its upper or lower neighbor per chain command.
// ----------------------------------------------------------------------------
module lsou_cell (
  input  logic               clk,
  input  lsou_pkg::cell_op_t op,
  input  lsou_pkg::cell_pos_t pos,
  input  lsou_pkg::data_t    up_data,    // neighbor above, push value at the top
  input  lsou_pkg::data_t    down_data,  // neighbor below
  input  lsou_pkg::data_t    top_data,   // top cell, for the dump wrap
  output lsou_pkg::data_t    value
);

  lsou_pkg::data_t value_next;

  always_comb begin
    value_next = value;
    case (op)
      lsou_pkg::CELL_PUSH: value_next = up_data;
      lsou_pkg::CELL_POP:  value_next = down_data;
      lsou_pkg::CELL_SWAP: begin
        if (pos.is_top) begin
          value_next = down_data;
        end else if (pos.is_second) begin
          value_next = up_data;
        end
      end
      lsou_pkg::CELL_ROT:  value_next = pos.is_bottom ? top_data : down_data;
      default:             value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// File: rtl/lsou_ctrl.sv
// ----------------------------------------------------------------------------
// lsou_ctrl
// Opcode decode, entry count, dump sequencer and result register.
// ----------------------------------------------------------------------------
module lsou_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [2:0]              opcode,
  input  lsou_pkg::data_t         top_value,
  output lsou_pkg::cell_op_t      cell_op,
  output lsou_pkg::count_t        count,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output lsou_pkg::data_t         m_data,
  output logic [2:0]              m_status,
  output logic                    m_last
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t                 state, state_next;
  lsou_pkg::count_t       count_next;
  lsou_pkg::count_t       remaining, remaining_next;
  logic                   m_tvalid_next;
  lsou_pkg::data_t        m_data_next;
  logic [2:0]             m_status_next;
  logic                   m_last_next;
  logic                   slot_free;
  logic                   accept;
  logic                   load;

  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && slot_free;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    state_next     = state;
    count_next     = count;
    remaining_next = remaining;
    cell_op        = lsou_pkg::CELL_HOLD;
    load           = 1'b0;
    m_data_next    = '0;
    m_status_next  = lsou_pkg::STS_DONE;
    m_last_next    = 1'b1;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (opcode)
            lsou_pkg::OP_PUSH: begin
              if (count == lsou_pkg::CNT_W'(lsou_pkg::STACK_DEPTH)) begin
                m_status_next = lsou_pkg::STS_OVERFLOW;
              end else begin
                cell_op    = lsou_pkg::CELL_PUSH;
                count_next = count + 1'b1;
              end
            end
            lsou_pkg::OP_DUMP: begin
              if (count != '0) begin
                load           = 1'b0;
                remaining_next = count;
                state_next     = ST_DUMP;
              end
            end
            lsou_pkg::OP_PEEK: begin
              if (count == '0) begin
                m_status_next = lsou_pkg::STS_PEEK_EMPTY;
              end else begin
                m_status_next = lsou_pkg::STS_DATA;
                m_data_next   = top_value;
              end
            end
            lsou_pkg::OP_POP: begin
              if (count == '0) begin
                m_status_next = lsou_pkg::STS_POP_EMPTY;
              end else begin
                cell_op    = lsou_pkg::CELL_POP;
                count_next = count - 1'b1;
              end
            end
            lsou_pkg::OP_SWAP: begin
              if (count < lsou_pkg::CNT_W'(2)) begin
                m_status_next = lsou_pkg::STS_SWAP_SHORT;
              end else begin
                cell_op = lsou_pkg::CELL_SWAP;
              end
            end
            default: m_status_next = lsou_pkg::STS_DONE;
          endcase
        end
      end
      ST_DUMP: begin
        // emit the top, then rotate; after count beats the stack is back in order
        if (slot_free) begin
          load           = 1'b1;
          m_data_next    = top_value;
          m_status_next  = lsou_pkg::STS_DATA;
          m_last_next    = (remaining == lsou_pkg::CNT_W'(1));
          cell_op        = lsou_pkg::CELL_ROT;
          remaining_next = remaining - 1'b1;
          if (remaining == lsou_pkg::CNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
    m_tvalid_next = load || (m_tvalid && !m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      remaining <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      m_tvalid  <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_data   <= m_data_next;
      m_status <= m_status_next;
      m_last   <= m_last_next;
    end
  end

endmodule

// File: sim/tb_lifo_stack_opcode_unit.sv
// ----------------------------------------------------------------------------
// tb_lifo_stack_opcode_unit
// Self-checking bench for the opcode-driven LIFO stack: a shadow stack
// predicts every result beat, and a scoreboard compares each one in order.
// It runs directed corner cases, a long output stall that fills the stack,
// and random opcode traffic under several idle patterns.
// ----------------------------------------------------------------------------
module tb_lifo_stack_opcode_unit;
  import lsou_pkg::*;

  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam data_t VAL_MIN = 32'sh8000_0000;
  localparam data_t VAL_MAX = 32'sh7fff_ffff;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    data_t   data;
    status_t status;
    logic    last;
  } result_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  // shadow stack, entry 0 is the bottom
  data_t        shadow_stack [STACK_DEPTH];
  int           shadow_depth = 0;
  result_beat_t expected_beats [$];

  int err_cnt    = 0;
  int idle_cyc   = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_req   = 0;
  int hold_ack   = 0;
  int hold_left  = 0;

  lifo_stack_opcode_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic expect_beat(data_t d, status_t s, logic l);
    result_beat_t b;
    b.data   = d;
    b.status = s;
    b.last   = l;
    expected_beats.push_back(b);
  endtask

  task automatic predict_stack_op(logic [2:0] op, data_t val);
    data_t t;
    case (op)
      OP_PUSH: begin
        if (shadow_depth >= STACK_DEPTH) begin
          expect_beat('0, STS_OVERFLOW, 1'b1);
        end else begin
          shadow_stack[shadow_depth] = val;
          shadow_depth++;
          expect_beat('0, STS_DONE, 1'b1);
        end
      end
      OP_DUMP: begin
        if (shadow_depth == 0) expect_beat('0, STS_DONE, 1'b1);
        for (int i = shadow_depth - 1; i >= 0; i--)
          expect_beat(shadow_stack[i], STS_DATA, i == 0);
      end
      OP_PEEK: begin
        if (shadow_depth == 0) expect_beat('0, STS_PEEK_EMPTY, 1'b1);
        else expect_beat(shadow_stack[shadow_depth-1], STS_DATA, 1'b1);
      end
      OP_POP: begin
        if (shadow_depth == 0) begin
          expect_beat('0, STS_POP_EMPTY, 1'b1);
        end else begin
          shadow_depth--;
          expect_beat('0, STS_DONE, 1'b1);
        end
      end
      OP_SWAP: begin
        if (shadow_depth < 2) begin
          expect_beat('0, STS_SWAP_SHORT, 1'b1);
        end else begin
          t = shadow_stack[shadow_depth-1];
          shadow_stack[shadow_depth-1] = shadow_stack[shadow_depth-2];
          shadow_stack[shadow_depth-2] = t;
          expect_beat('0, STS_DONE, 1'b1);
        end
      end
      default: expect_beat('0, STS_DONE, 1'b1);
    endcase
  endtask

  // Input side is predicted before the output side is checked, so the
  // order of processes at one edge does not matter.
  always @(posedge clk) begin
    result_beat_t b;
    if (!rst) begin
      if (s_tvalid && s_tready) predict_stack_op(s_tuser, data_t'(s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_beats.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected beat: data=%0d status=%0d last=%0b",
                     $signed(m_tdata), m_tuser, m_tlast);
        end else begin
          b = expected_beats.pop_front();
          if (m_tdata !== b.data || m_tuser !== b.status || m_tlast !== b.last) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"mismatch: exp data=%0d status=%0d last=%0b,",
                        " got data=%0d status=%0d last=%0b"},
                       b.data, b.status, b.last, $signed(m_tdata), m_tuser, m_tlast);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= STALL_LIMIT) begin
        $display("lifo_stack_opcode_unit regression: fail");
        $finish;
      end
    end
  end

  // output backpressure; a long hold-off is counted here when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_req;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  task automatic send_op(logic [2:0] op, data_t val);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < snd_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= val;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic data_t rand_value();
    case ($urandom_range(0, 3))
      0: return VAL_MIN + data_t'($urandom_range(0, 3));
      1: return VAL_MAX - data_t'($urandom_range(0, 3));
      2: return data_t'($urandom_range(0, 16)) - 8;
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic test_empty_stack();
    send_op(OP_PEEK, rand_value());
    send_op(OP_POP,  rand_value());
    send_op(OP_SWAP, rand_value());
    send_op(OP_DUMP, rand_value());
    send_op(OP_RSVD5, rand_value());
    send_op(OP_RSVD6, rand_value());
    send_op(OP_RSVD7, rand_value());
  endtask

  // leaves the stack empty
  task automatic test_basic_ops();
    send_op(OP_PUSH, VAL_MIN);
    send_op(OP_PUSH, VAL_MAX);
    send_op(OP_PEEK, '0);
    send_op(OP_SWAP, '0);
    send_op(OP_PEEK, '0);
    send_op(OP_DUMP, '0);
    send_op(OP_PUSH, '0);
    send_op(OP_PUSH, -1);
    send_op(OP_SWAP, '0);
    send_op(OP_DUMP, '0);
    repeat (3) send_op(OP_POP, '0);
    send_op(OP_SWAP, '0);   // one entry left: too short
    send_op(OP_POP, '0);
  endtask

  // receiver stalls while pushes keep coming; ends with a full stack
  task automatic test_fill_under_stall();
    int saved = snd_idle_pct;
    snd_idle_pct = 0;
    hold_req++;
    repeat (STACK_DEPTH + 2) send_op(OP_PUSH, rand_value());
    snd_idle_pct = saved;
    send_op(OP_DUMP, '0);
    send_op(OP_PEEK, '0);
  endtask

  task automatic test_random_ops(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (shadow_depth > 48 && r < 40) r = r + 40;
      if (r < 40)      send_op(OP_PUSH, rand_value());
      else if (r < 46) send_op(OP_DUMP, rand_value());
      else if (r < 62) send_op(OP_PEEK, rand_value());
      else if (r < 82) send_op(OP_POP,  rand_value());
      else if (r < 95) send_op(OP_SWAP, rand_value());
      else             send_op(3'($urandom_range(5, 7)), rand_value());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    snd_idle_pct = 38;
    rcv_idle_pct = 48;
    test_empty_stack();
    test_basic_ops();
    test_fill_under_stall();
    test_random_ops(45);

    snd_idle_pct = 48;
    rcv_idle_pct = 38;
    test_random_ops(45);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_ops(45);

    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0 && expected_beats.size() == 0) begin
      $display("lifo_stack_opcode_unit regression: pass");
    end else begin
      $display("lifo_stack_opcode_unit regression: fail");
    end
    $finish;
  end

endmodule
